### rtl/core/swm_pkg.sv
// Shared constants and codes for the star wildcard matcher.
package swm_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned LenW       = $clog2(PatternMax + 1);
  localparam int unsigned PosW       = PatternMax + 1;
  localparam int unsigned AddrW      = $clog2(PatternMax);

  localparam logic [7:0] StarByte = 8'd42;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpText   = 2'd1;
  localparam logic [1:0] OpEnd    = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

endpackage

### rtl/core/swm_core.sv
// Pattern store and live-position automaton of the star wildcard matcher.
module swm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        sym_i,
  output swm_pkg::result_t  result_o
);

  logic [7:0]                         store_q [swm_pkg::PatternMax];
  logic [swm_pkg::PatternMax-1:0]     star_q;
  logic [swm_pkg::LenW-1:0]           len_q, len_d;
  logic [swm_pkg::PosW-1:0]           live_q, live_d;
  logic [swm_pkg::PosW-1:0]           init_q, init_d;
  logic                               ovf_q, ovf_d;

  logic [swm_pkg::PosW-1:0]           len_bit;
  logic [swm_pkg::PosW-1:0]           below_len;
  logic [swm_pkg::PatternMax-1:0]     star_v;
  logic [swm_pkg::PatternMax-1:0]     hit_v;
  logic [swm_pkg::PosW-1:0]           seed;
  logic [swm_pkg::PosW-1:0]           span;
  logic [swm_pkg::PosW:0]             span_sum;
  logic [swm_pkg::PosW-1:0]           advanced;
  logic                               sym_star;
  logic                               full;

  assign len_bit   = swm_pkg::PosW'(1) << len_q;
  assign below_len = len_bit - swm_pkg::PosW'(1);
  assign sym_star  = (sym_i == swm_pkg::StarByte);
  assign full      = (len_q == swm_pkg::LenW'(swm_pkg::PatternMax));

  always_comb begin
    for (int i = 0; i < swm_pkg::PatternMax; i++) begin
      star_v[i] = star_q[i] & below_len[i];
      hit_v[i]  = ~star_q[i] & below_len[i] & (store_q[i] == sym_i);
    end
  end

  // The live set is kept closed under stars. A text byte keeps star positions
  // and moves matching literal positions on; the new set is then closed again.
  // Runs of stars fill upward from a seed through the carry chain of one add.
  assign seed = {1'b0, live_q[swm_pkg::PatternMax-1:0] & star_v}
              | {live_q[swm_pkg::PatternMax-1:0] & hit_v, 1'b0};
  assign span = {star_v, 1'b0} | seed;
  assign span_sum = {1'b0, span} + {1'b0, seed};
  assign advanced = seed | ((span_sum[swm_pkg::PosW-1:0] ^ span) & span);

  always_comb begin
    len_d  = len_q;
    live_d = live_q;
    init_d = init_q;
    ovf_d  = ovf_q;
    if (step_i) begin
      case (op_i)
        swm_pkg::OpAppend: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + swm_pkg::LenW'(1);
            // A new star at the end extends closure by exactly one position.
            if (sym_star) begin
              live_d = live_q | ((live_q & len_bit) << 1);
              init_d = init_q | ((init_q & len_bit) << 1);
            end
          end
        end
        swm_pkg::OpText: begin
          live_d = advanced;
        end
        swm_pkg::OpEnd: begin
          live_d = init_q;
        end
        swm_pkg::OpClear: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          live_d = swm_pkg::PosW'(1);
          init_d = swm_pkg::PosW'(1);
        end
        default: begin
          live_d = live_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      live_q <= swm_pkg::PosW'(1);
      init_q <= swm_pkg::PosW'(1);
      ovf_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      live_q <= live_d;
      init_q <= init_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && (op_i == swm_pkg::OpAppend) && !full) begin
      store_q[len_q[swm_pkg::AddrW-1:0]] <= sym_i;
      star_q[len_q[swm_pkg::AddrW-1:0]]  <= sym_star;
    end
  end

  assign result_o.matched  = !ovf_q && ((live_q & len_bit) != '0);
  assign result_o.overflow = ovf_q;

endmodule

### rtl/core/star_wildcard_matcher.sv
// Top level of the star wildcard matcher: stream ports, input and result registers.
//
// Glob matcher where '*' matches any run of bytes and other bytes match
// themselves. Each input word carries a kind in s_axis_tuser and a byte in
// s_axis_tdata: append a pattern byte, feed a text byte, end the text, or
// clear the pattern. Only an end-of-text word produces a result word on the
// master side, carrying the match bit and the sticky overflow flag.
// Input words are registered, then processed by the position-set automaton,
// which updates its state and loads the result register. One word is taken
// per cycle while s_axis_tready is high; the rate is set by the single pass
// through the parallel position-set update.
// When a result waits and the receiver holds m_axis_tready low, the block
// keeps taking words until an end-of-text word reaches the processing stage;
// only then is s_axis_tready dropped until the result is taken.
// Reset empties the pattern, clears the overflow flag and restarts the text.
// Appending beyond 32 pattern bytes drops the byte and sets overflow.
module star_wildcard_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

  logic              in_valid_q;
  logic [1:0]        op_q;
  logic [7:0]        sym_q;
  logic              out_valid_q;
  swm_pkg::result_t  res_q;
  swm_pkg::result_t  res;
  logic              stall;
  logic              step;

  assign stall = in_valid_q && (op_q == swm_pkg::OpEnd) && out_valid_q && !m_axis_tready;
  assign step  = in_valid_q && !stall;
  assign s_axis_tready = !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step && (op_q == swm_pkg::OpEnd)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && s_axis_tvalid) begin
      op_q  <= s_axis_tuser;
      sym_q <= s_axis_tdata;
    end
    if (step && (op_q == swm_pkg::OpEnd)) begin
      res_q <= res;
    end
  end

  swm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .op_i     (op_q),
    .sym_i    (sym_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.overflow, res_q.matched};

endmodule

### rtl/core/swm_checker.sv
// Port-level checks for the star wildcard matcher, bound to the top level.
module swm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A waiting result word holds its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A fresh result word must be caused by an accepted end-of-text word.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_acc && (s_axis_tuser == swm_pkg::OpEnd), 2))
    else $error("result word without a matching end-of-text word");

  // Overflow forces a miss.
  a_ovf_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("match reported with overflow set");

  // Padding bits of the result word stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0))
    else $error("nonzero padding in result word");

  // The input side only stalls while a result word is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no waiting result");

  logic unused_data;
  assign unused_data = ^s_axis_tdata;

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
